[rtl/sorm_pkg.sv]
// Shared constants for the spiral-order matrix reorder block.
// Field widths, register indexes and default dimensions; no dependencies.
package sorm_pkg;

  // Payload and register widths.
  localparam int unsigned DataW  = 32;
  localparam int unsigned DimW   = 4;
  localparam int unsigned CntW   = 7;
  localparam int unsigned TotW   = 2 * DimW;
  localparam int unsigned CfgIdxW = 2;

  // Default matrix size limits.
  localparam int unsigned MaxRowsDef = 8;
  localparam int unsigned MaxColsDef = 8;

  // Reset value of both dimension registers.
  localparam logic [DimW-1:0] DimReset = 4'd8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRowCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegColCount = 2'd1;

endpackage

[rtl/sorm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sorm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/spiral_order_matrix_reorder.sv]
// Spiral-order matrix reorder: elements arrive one per beat in row-major order.
// Each accepted beat stores one element; the beat that completes the matrix starts a walk
// that emits rows*cols results, one per cycle, the first once the walk state is entered and
// the element RAM read data is registered. The walk is paced by the single read port of the
// element RAM; busy is high while the walk reads the RAM. The receiver cannot stall. Reset
// sets both dimensions to 8 and the load count to zero; the element RAM is not cleared.
module spiral_order_matrix_reorder #(
  parameter int unsigned MAX_ROWS = sorm_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = sorm_pkg::MaxColsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sorm_pkg::DataW-1:0]  element_value_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sorm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sorm_pkg::DimW-1:0]          cfg_data_i,
  output logic                               out_strobe_o,
  output logic signed [sorm_pkg::DataW-1:0]  out_value_o,
  output logic                               last_of_run_o
);

  import sorm_pkg::*;

  localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Cells > 1) ? $clog2(Cells) : 1;

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  typedef enum logic [1:0] {
    DirRight,
    DirDown,
    DirLeft,
    DirUp
  } dir_e;

  state_e           state_q;
  dir_e             dir_q, dir_d;
  logic [DimW-1:0]  row_count_q, column_count_q;
  logic [CntW-1:0]  loaded_q;
  logic [DimW-1:0]  r_q, r_d, c_q, c_d;
  logic [DimW-1:0]  top_q, top_d, bot_q, bot_d, left_q, left_d, right_q, right_d;
  logic [DimW-1:0]  cols_q;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [TotW-1:0]  remain_q;
  logic             strobe_q, last_q;

  logic [DimW-1:0]  rows, cols;
  logic [TotW-1:0]  total;
  logic [CntW-1:0]  loaded_inc;
  logic             accept, walk_now;
  logic             ram_we;
  logic [DataW-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q == StWalk);
  assign accept      = start && !busy;

  // Clamp the dimension registers to 1..limit.
  always_comb begin
    if (row_count_q == '0) begin
      rows = DimW'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rows = DimW'(MAX_ROWS);
    end else begin
      rows = row_count_q;
    end
    if (column_count_q == '0) begin
      cols = DimW'(1);
    end else if (32'(column_count_q) > MAX_COLS) begin
      cols = DimW'(MAX_COLS);
    end else begin
      cols = column_count_q;
    end
  end

  assign total      = TotW'(rows) * TotW'(cols);
  assign loaded_inc = loaded_q + CntW'(1);
  assign walk_now   = ({1'b0, loaded_inc} >= total);
  assign ram_we     = accept && (32'(loaded_q) < Cells);

  // Next walk position: turn right at the edge of the shrinking boundary, then step.
  always_comb begin
    dir_d   = dir_q;
    top_d   = top_q;
    bot_d   = bot_q;
    left_d  = left_q;
    right_d = right_q;
    unique case (dir_q)
      DirRight: begin
        if (c_q == right_q) begin
          dir_d = DirDown;
          top_d = top_q + DimW'(1);
        end
      end
      DirDown: begin
        if (r_q == bot_q) begin
          dir_d   = DirLeft;
          right_d = right_q - DimW'(1);
        end
      end
      DirLeft: begin
        if (c_q == left_q) begin
          dir_d = DirUp;
          bot_d = bot_q - DimW'(1);
        end
      end
      DirUp: begin
        if (r_q == top_q) begin
          dir_d  = DirRight;
          left_d = left_q + DimW'(1);
        end
      end
      default: ;
    endcase
    r_d   = r_q;
    c_d   = c_q;
    idx_d = idx_q;
    unique case (dir_d)
      DirRight: begin
        c_d   = c_q + DimW'(1);
        idx_d = idx_q + AddrW'(1);
      end
      DirDown: begin
        r_d   = r_q + DimW'(1);
        idx_d = idx_q + AddrW'(cols_q);
      end
      DirLeft: begin
        c_d   = c_q - DimW'(1);
        idx_d = idx_q - AddrW'(1);
      end
      DirUp: begin
        r_d   = r_q - DimW'(1);
        idx_d = idx_q - AddrW'(cols_q);
      end
      default: ;
    endcase
  end

  // Control state, configuration registers, walk registers and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      row_count_q    <= DimReset;
      column_count_q <= DimReset;
      loaded_q       <= '0;
      strobe_q       <= 1'b0;
      last_q         <= 1'b0;
      dir_q          <= DirRight;
      r_q            <= '0;
      c_q            <= '0;
      top_q          <= '0;
      bot_q          <= '0;
      left_q         <= '0;
      right_q        <= '0;
      cols_q         <= '0;
      idx_q          <= '0;
      remain_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegRowCount) begin
          row_count_q <= cfg_data_i;
        end else if (cfg_index_i == RegColCount) begin
          column_count_q <= cfg_data_i;
        end
      end
      strobe_q <= busy;
      last_q   <= busy && (remain_q == '0);
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (walk_now) begin
              state_q  <= StWalk;
              loaded_q <= '0;
              dir_q    <= DirRight;
              r_q      <= '0;
              c_q      <= '0;
              idx_q    <= '0;
              top_q    <= '0;
              left_q   <= '0;
              bot_q    <= rows - DimW'(1);
              right_q  <= cols - DimW'(1);
              cols_q   <= cols;
              remain_q <= total - TotW'(1);
            end else begin
              loaded_q <= loaded_inc;
            end
          end
        end
        StWalk: begin
          dir_q    <= dir_d;
          r_q      <= r_d;
          c_q      <= c_d;
          idx_q    <= idx_d;
          top_q    <= top_d;
          bot_q    <= bot_d;
          left_q   <= left_d;
          right_q  <= right_d;
          remain_q <= remain_q - TotW'(1);
          if (remain_q == '0) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Element store: written while loading, read once per walk cycle.
  sorm_ram #(
    .Width(DataW),
    .Depth(Cells),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(loaded_q)),
    .wdata_i(element_value_i),
    .re_i   (busy),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign out_strobe_o  = strobe_q;
  assign out_value_o   = ram_rdata;
  assign last_of_run_o = last_q;

endmodule

[sim/testbench.sv]
// Self-checking testbench for spiral_order_matrix_reorder.
// Loads matrices of many shapes, predicts the spiral walk and checks every result beat.
// Depends on sorm_pkg and the block's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sorm_pkg::*;

  localparam int unsigned MaxRows      = MaxRowsDef;
  localparam int unsigned MaxCols      = MaxColsDef;
  localparam int unsigned Cells        = MaxRows * MaxCols;
  localparam int unsigned TotalItems   = 330;
  localparam int unsigned SettleCycles = 8;

  // Register indexes that decode to nothing; written to exercise the index bits.
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  typedef enum int {HeadRight, HeadDown, HeadLeft, HeadUp} heading_e;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } spiral_beat_t;

  // Block ports, all inputs known from time zero.
  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      start           = 1'b0;
  logic                      busy;
  logic signed [DataW-1:0]   element_value_i = '0;
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i     = '0;
  logic [DimW-1:0]           cfg_data_i      = '0;
  logic                      out_strobe_o;
  logic signed [DataW-1:0]   out_value_o;
  logic                      last_of_run_o;

  // Shadow state of the block, as seen through its ports.
  logic [DataW-1:0]  elem_store [Cells];
  logic [CntW-1:0]   load_cnt = '0;
  logic [DimW-1:0]   row_reg  = DimReset;
  logic [DimW-1:0]   col_reg  = DimReset;
  spiral_beat_t      spiral_expect [$];

  int unsigned items_sent    = 0;
  int unsigned walks_done    = 0;
  int unsigned beats_checked = 0;
  int unsigned fail_count    = 0;
  bit          steady        = 1'b0;

  spiral_order_matrix_reorder #(
    .MAX_ROWS(MaxRows),
    .MAX_COLS(MaxCols)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .element_value_i(element_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_strobe_o   (out_strobe_o),
    .out_value_o    (out_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #5ns clk_i = ~clk_i;

  // A zero register means one, anything above the limit saturates.
  function automatic int dim_eff(logic [DimW-1:0] dim_reg, int limit);
    if (dim_reg == '0) return 1;
    if (int'(dim_reg) > limit) return limit;
    return int'(dim_reg);
  endfunction

  function automatic int current_total();
    return dim_eff(row_reg, MaxRows) * dim_eff(col_reg, MaxCols);
  endfunction

  function automatic int row_step(heading_e h);
    case (h)
      HeadDown: return 1;
      HeadUp:   return -1;
      default:  return 0;
    endcase
  endfunction

  function automatic int col_step(heading_e h);
    case (h)
      HeadRight: return 1;
      HeadLeft:  return -1;
      default:   return 0;
    endcase
  endfunction

  // Store one element; when the matrix is complete, queue the whole spiral walk.
  function automatic void absorb_element(logic [DataW-1:0] v);
    int rows, cols, total, r, c, nr, nc, idx;
    heading_e dir;
    logic [Cells-1:0] seen;
    spiral_beat_t beat;
    rows  = dim_eff(row_reg, MaxRows);
    cols  = dim_eff(col_reg, MaxCols);
    total = rows * cols;
    if (load_cnt < Cells) elem_store[load_cnt] = v;
    load_cnt = load_cnt + CntW'(1);
    if (int'(load_cnt) < total) return;
    seen = '0;
    r    = 0;
    c    = 0;
    dir  = HeadRight;
    for (int k = 0; k < total; k++) begin
      beat.value = '0;
      if (r >= 0 && r < rows && c >= 0 && c < cols) begin
        idx        = r * cols + c;
        beat.value = elem_store[idx];
        seen[idx]  = 1'b1;
      end
      beat.last = (k == total - 1);
      spiral_expect = {spiral_expect, beat};
      // Turn clockwise when the cell ahead is outside or already visited.
      nr = r + row_step(dir);
      nc = c + col_step(dir);
      if (nr < 0 || nr >= rows || nc < 0 || nc >= cols || seen[nr * cols + nc]) begin
        dir = heading_e'((int'(dir) + 1) % 4);
      end
      r += row_step(dir);
      c += col_step(dir);
    end
    load_cnt = '0;
    walks_done++;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // Every strobed beat is compared with the oldest expectation.
  always @(posedge clk_i) begin
    spiral_beat_t want;
    if (rst_ni && out_strobe_o) begin
      if (spiral_expect.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected, value %0d", out_value_o));
      end else begin
        want = spiral_expect.pop_front();
        if (out_value_o !== want.value)
          report_mismatch($sformatf("out_value %0d, expected %0d", out_value_o, want.value));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last_of_run %b, expected %b", last_of_run_o, want.last));
        beats_checked++;
      end
    end
  end

  // Mostly short gaps, a few long ones, none at all in steady phases.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [DataW-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DimW-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DimW'($urandom_range(9, 15));
      default: return DimW'($urandom_range(1, 8));
    endcase
  endfunction

  // Send one element beat; start stays high if the next beat follows at once.
  task automatic send_element(logic [DataW-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (busy);
    absorb_element(v);
    items_sent++;
  endtask

  // Stop sending, let every expected beat arrive, then let the walk wind down.
  task automatic settle_block();
    start <= 1'b0;
    while (spiral_expect.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegRowCount: row_reg = data;
      RegColCount: col_reg = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reconfigure the matrix size once the block is quiet, sometimes also a spare index.
  task automatic set_dims(logic [DimW-1:0] rows, logic [DimW-1:0] cols);
    settle_block();
    if ($urandom_range(0, 1) == 0) begin
      write_register(RegRowCount, rows);
      write_register(RegColCount, cols);
    end else begin
      write_register(RegColCount, cols);
      write_register(RegRowCount, rows);
    end
    if ($urandom_range(0, 2) == 0)
      write_register($urandom_range(0, 1) ? RegSpareA : RegSpareB, DimW'($urandom_range(0, 15)));
  endtask

  // Keep loading random elements until the walk has fired.
  task automatic load_matrix();
    do send_element(rand_element()); while (load_cnt != 0);
  endtask

  // Reset dimensions are 8 by 8; the first elements are the value extremes.
  task automatic test_reset_size();
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'hAAAA_AAAA);
    send_element(32'h5555_5555);
    load_matrix();
  endtask

  // A single row and a single column, each filled with fixed edge-case values.
  task automatic test_thin_matrices();
    set_dims(4'd1, 4'd4);
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    set_dims(4'd4, 4'd1);
    send_element(32'hAAAA_AAAA);
    send_element(32'h5555_5555);
    send_element(32'h0000_0001);
    send_element(32'h8000_0001);
  endtask

  // Zero dimensions act as one: a single element comes straight back as the last beat.
  task automatic test_zero_dims();
    set_dims(4'd0, 4'd0);
    send_element(32'hDEAD_BEEF);
  endtask

  // Register values above the limit saturate to the maximum size.
  task automatic test_saturated_dims();
    set_dims(4'd15, 4'd1);
    load_matrix();
    set_dims(4'd1, 4'd9);
    load_matrix();
  endtask

  // Shrinking below the loaded count starts the walk on the next beat; growing extends the load.
  task automatic test_resize_mid_load();
    set_dims(4'd3, 4'd3);
    repeat (5) send_element(rand_element());
    set_dims(4'd2, 4'd2);
    send_element(rand_element());
    repeat (2) send_element(rand_element());
    set_dims(4'd3, 4'd3);
    load_matrix();
  endtask

  // Random shapes and contents, with the occasional resize part-way through a load.
  task automatic test_random_matrices();
    while (items_sent < TotalItems) begin
      steady = ($urandom_range(0, 3) == 0);
      set_dims(rand_dim(), rand_dim());
      repeat ($urandom_range(1, 3)) begin
        if (items_sent >= TotalItems) break;
        if ($urandom_range(0, 5) == 0 && current_total() > 1) begin
          repeat ($urandom_range(1, current_total() - 1)) send_element(rand_element());
          set_dims(rand_dim(), rand_dim());
        end
        load_matrix();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_thin_matrices();
    test_zero_dims();
    test_saturated_dims();
    test_resize_mid_load();
    test_random_matrices();
    settle_block();
    $display("Run covered %0d element beats over %0d spiral walks.", items_sent, walks_done);
    $display("%0d result beats compared, %0d mismatches.", beats_checked, fail_count);
    if (fail_count == 0 && spiral_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("Timed out with %0d beats still expected.", spiral_expect.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
rtl/sorm_pkg.sv
rtl/sorm_ram.sv
rtl/spiral_order_matrix_reorder.sv
sim/testbench.sv
